@@ sv/gdc_pkg.sv @@
// Shared types, constants and helpers for the graph distance and component block.
// Used by gdc_cell, the top level graph_distance_and_components and its checker.
// Depends on nothing else.
`default_nettype none

package gdc_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_NODES_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  // Fixed port widths.
  localparam int ROW_W         = 4;
  localparam int WEIGHT_IN_W   = 8;
  localparam int DIST_OUT_W    = 12;
  localparam int COUNT_OUT_W   = 5;
  localparam int NODE_COUNT_W  = 5;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // Saturation limits of the result fields.
  localparam int DIST_SAT  = 4095;
  localparam int COUNT_SAT = 31;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Width that holds the longest simple path over all nodes.
  function automatic int dist_width(input int max_nodes, input int weight_bits);
    int longest;
    longest = (max_nodes - 1) * ((1 << weight_bits) - 1) + 1;
    return $clog2(longest) < 1 ? 1 : $clog2(longest);
  endfunction

  // Control word broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             clr_all;
    logic             seed;
    logic             prop;
    logic             clr_cur;
    logic             bf_init;
    logic             relax;
    logic [ROW_W-1:0] src;
  } gdc_ctl_t;

endpackage

`default_nettype wire

@@ sv/gdc_cell.sv @@
// One node of the cell row: its incoming edge weights, its distance and its marks.
// Depends on gdc_pkg; instantiated once per node by graph_distance_and_components.
`default_nettype none

module gdc_cell #(
  parameter int MAX_NODES   = gdc_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gdc_pkg::WEIGHT_BITS_DEF,
  parameter int DIST_W      = gdc_pkg::dist_width(gdc_pkg::MAX_NODES_DEF,
                                                  gdc_pkg::WEIGHT_BITS_DEF),
  parameter int IDX         = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          active,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_NODES)-1:0]  wr_row,
  input  wire logic [WEIGHT_BITS-1:0]        wr_data,
  input  wire gdc_pkg::gdc_ctl_t             ctl,
  input  wire logic [MAX_NODES-1:0]          cur_vec,
  input  wire logic [$clog2(MAX_NODES)-1:0]  u_idx,
  input  wire logic [DIST_W-1:0]             du,
  input  wire logic                          du_valid,
  input  wire logic                          found_in,
  output logic                               found_out,
  output logic                               cur_o,
  output logic                               join_o,
  output logic                               chg_o,
  output logic                               dvalid_o,
  output logic [DIST_W-1:0]                  dist_o
);

  logic [WEIGHT_BITS-1:0] col_r [MAX_NODES];
  logic                   marked_r;
  logic                   cur_r;
  logic                   dvalid_r;
  logic [DIST_W-1:0]      dist_r;

  logic [MAX_NODES-1:0]   nz;
  logic                   is_first;
  logic [WEIGHT_BITS-1:0] w_sel;
  logic [DIST_W:0]        sum;
  logic                   upd;

  // Which nodes have an edge into this one.
  always_comb begin
    for (int u = 0; u < MAX_NODES; u++) begin
      nz[u] = (col_r[u] != '0);
    end
  end

  // Priority chain: the first active unmarked node seeds the next component.
  assign is_first  = active && !marked_r && !found_in;
  assign found_out = found_in || (active && !marked_r);

  // An unmarked node joins the current component when an edge from one of its nodes reaches here.
  assign join_o = active && !marked_r && ((cur_vec & nz) != '0);

  // Relaxation against the broadcast row.
  assign w_sel = col_r[u_idx];
  assign sum   = {1'b0, du} + (DIST_W + 1)'(w_sel);
  assign upd   = ctl.relax && active && (w_sel != '0) && du_valid &&
                 (!dvalid_r || (sum < {1'b0, dist_r}));
  assign chg_o = upd;

  // Weight store and marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < MAX_NODES; u++) begin
        col_r[u] <= '0;
      end
      marked_r <= 1'b0;
      cur_r    <= 1'b0;
      dvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        col_r[wr_row] <= wr_data;
      end
      if (ctl.clr_all) begin
        marked_r <= 1'b0;
        cur_r    <= 1'b0;
        dvalid_r <= 1'b0;
      end else begin
        if ((ctl.seed && is_first) || (ctl.prop && join_o)) begin
          marked_r <= 1'b1;
          cur_r    <= 1'b1;
        end
        if (ctl.clr_cur) begin
          cur_r <= 1'b0;
        end
        if (ctl.bf_init) begin
          dvalid_r <= (IDX == int'(ctl.src));
        end else if (upd) begin
          dvalid_r <= 1'b1;
        end
      end
    end
  end

  // Distance value.
  always_ff @(posedge clk) begin
    if (ctl.bf_init) begin
      dist_r <= '0;
    end else if (upd) begin
      dist_r <= DIST_W'(sum);
    end
  end

  assign cur_o    = cur_r;
  assign dvalid_o = dvalid_r;
  assign dist_o   = dist_r;

endmodule

`default_nettype wire

@@ sv/graph_distance_and_components.sv @@
// Operation: an edge write is taken while idle and gives no result. A query runs a component scan
// (a seed step and propagation steps per component), then, if both endpoints are in range, relaxation
// rounds (one source row per cycle, fewer rounds when a round settles) and a done step, then strobes its result.
// Throughput: one word at a time; no new word is taken while busy; the receiver cannot stall.
// Reset clears the whole weight store at once and sets node_count to 16.
// Depends on gdc_pkg and gdc_cell.
`default_nettype none

module graph_distance_and_components #(
  parameter int MAX_NODES   = gdc_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gdc_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_cmd,
  input  wire logic [gdc_pkg::ROW_W-1:0]          in_row,
  input  wire logic [gdc_pkg::ROW_W-1:0]          in_col,
  input  wire logic [gdc_pkg::WEIGHT_IN_W-1:0]    in_weight,
  input  wire logic                               cfg_we,
  input  wire logic [gdc_pkg::NODE_COUNT_W-1:0]   cfg_wdata,
  output logic                                    out_valid,
  output logic [gdc_pkg::DIST_OUT_W-1:0]          out_distance,
  output logic                                    out_reachable,
  output logic [gdc_pkg::COUNT_OUT_W-1:0]         out_component_count
);

  localparam int NIW    = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int DIST_W = gdc_pkg::dist_width(MAX_NODES, WEIGHT_BITS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CSEL  = 5'b00010,
    S_CPROP = 5'b00100,
    S_BF    = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [gdc_pkg::NODE_COUNT_W-1:0]  node_count_r;
  logic [CW-1:0]                     n_r;
  logic [gdc_pkg::ROW_W-1:0]         src_r, dst_r;
  logic                              ep_ok_r;
  logic [CW-1:0]                     comp_r;
  logic [NIW-1:0]                    u_r;
  logic [NIW-1:0]                    round_r;
  logic                              rchg_r;

  logic                              out_valid_r;
  logic [gdc_pkg::DIST_OUT_W-1:0]    out_dist_r;
  logic                              out_reach_r;
  logic [gdc_pkg::COUNT_OUT_W-1:0]   out_comp_r;

  logic [CW-1:0]                     n_eff;
  logic                              acc_query, acc_write, wr_ok;
  gdc_pkg::gdc_ctl_t                 ctl;
  logic [MAX_NODES:0]                found;
  logic [MAX_NODES-1:0]              cur_vec, join_vec, chg_vec, dvalid_vec, active_vec;
  logic [DIST_W-1:0]                 dist_vec [MAX_NODES];
  logic                              any_join, any_chg, last_u, last_round;
  logic [NIW-1:0]                    dst_ix;

  // Effective node count and accepted commands.
  assign n_eff     = (int'(node_count_r) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign busy      = (state_r != S_IDLE);
  assign acc_query = start && !busy && (in_cmd == gdc_pkg::CMD_QUERY);
  assign acc_write = start && !busy && (in_cmd == gdc_pkg::CMD_WRITE);
  assign wr_ok     = acc_write && (int'(in_row) < MAX_NODES) && (int'(in_col) < MAX_NODES);

  // The row of node cells.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    assign active_vec[i] = (i < int'(n_r));
    gdc_cell #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .DIST_W      (DIST_W),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .active    (active_vec[i]),
      .wr_en     (wr_ok && (int'(in_col) == i)),
      .wr_row    (NIW'(in_row)),
      .wr_data   (WEIGHT_BITS'(in_weight)),
      .ctl       (ctl),
      .cur_vec   (cur_vec),
      .u_idx     (u_r),
      .du        (dist_vec[u_r]),
      .du_valid  (dvalid_vec[u_r]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .cur_o     (cur_vec[i]),
      .join_o    (join_vec[i]),
      .chg_o     (chg_vec[i]),
      .dvalid_o  (dvalid_vec[i]),
      .dist_o    (dist_vec[i])
    );
  end

  assign any_join   = (join_vec != '0);
  assign any_chg    = (chg_vec != '0);
  assign last_u     = ((CW'(u_r) + 1'b1) == n_r);
  assign last_round = ((CW'(round_r) + 1'b1) == n_r);
  assign dst_ix     = NIW'(dst_r);

  // Sequencer: component scan, then relaxation rounds if both endpoints are in range, then the result.
  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    ctl.src     = src_r;
    ctl.clr_all = acc_query;
    unique case (state_r)
      S_IDLE: begin
        if (acc_query) state_nxt = S_CSEL;
      end
      S_CSEL: begin
        if (found[MAX_NODES]) begin
          ctl.seed  = 1'b1;
          state_nxt = S_CPROP;
        end else if (ep_ok_r) begin
          ctl.bf_init = 1'b1;
          state_nxt   = S_BF;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CPROP: begin
        ctl.prop = 1'b1;
        if (!any_join) begin
          ctl.clr_cur = 1'b1;
          state_nxt   = S_CSEL;
        end
      end
      S_BF: begin
        ctl.relax = 1'b1;
        if (last_u && (last_round || !(rchg_r || any_chg))) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= gdc_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
      comp_r       <= '0;
      u_r          <= '0;
      round_r      <= '0;
      rchg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (acc_query) begin
        comp_r <= '0;
      end else if (ctl.seed) begin
        comp_r <= comp_r + 1'b1;
      end
      if (ctl.bf_init) begin
        u_r     <= '0;
        round_r <= '0;
        rchg_r  <= 1'b0;
      end else if (ctl.relax) begin
        if (last_u) begin
          u_r     <= '0;
          round_r <= round_r + 1'b1;
          rchg_r  <= 1'b0;
        end else begin
          u_r    <= u_r + 1'b1;
          rchg_r <= rchg_r || any_chg;
        end
      end
    end
  end

  // Query operands, held for the whole query.
  always_ff @(posedge clk) begin
    if (acc_query) begin
      n_r     <= n_eff;
      src_r   <= in_row;
      dst_r   <= in_col;
      ep_ok_r <= (int'(in_row) < int'(n_eff)) && (int'(in_col) < int'(n_eff));
    end
  end

  // Result word register with saturation.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      if (ep_ok_r && dvalid_vec[dst_ix]) begin
        out_reach_r <= 1'b1;
        out_dist_r  <= (32'(dist_vec[dst_ix]) > gdc_pkg::DIST_SAT) ?
                       gdc_pkg::DIST_OUT_W'(gdc_pkg::DIST_SAT) :
                       gdc_pkg::DIST_OUT_W'(dist_vec[dst_ix]);
      end else begin
        out_reach_r <= 1'b0;
        out_dist_r  <= '0;
      end
      out_comp_r <= (32'(comp_r) > gdc_pkg::COUNT_SAT) ?
                    gdc_pkg::COUNT_OUT_W'(gdc_pkg::COUNT_SAT) :
                    gdc_pkg::COUNT_OUT_W'(comp_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_distance        = out_dist_r;
  assign out_reachable       = out_reach_r;
  assign out_component_count = out_comp_r;

endmodule

`default_nettype wire

@@ sv/gdc_checker.sv @@
// Port-level checker for graph_distance_and_components, bound to the top level.
// Depends on gdc_pkg for the port widths.
`default_nettype none

module gdc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             in_cmd,
  input wire logic                             out_valid,
  input wire logic [gdc_pkg::DIST_OUT_W-1:0]   out_distance,
  input wire logic                             out_reachable
);

  // A query word makes the block busy at once.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == gdc_pkg::CMD_QUERY) |=> busy)
    else $error("query not taken up");

  // A write word never makes the block busy.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == gdc_pkg::CMD_WRITE) |=> !busy)
    else $error("write held the block busy");

  // A result follows directly on the end of a busy spell.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a finished query");

  // An unreachable destination reports zero distance.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> (out_distance == '0))
    else $error("nonzero distance when unreachable");

endmodule

bind graph_distance_and_components gdc_checker u_gdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_distance  (out_distance),
  .out_reachable (out_reachable)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for graph_distance_and_components: edge writes and distance/component queries.
// Predicts each query result from its own copy of the weight store and node count.
// Depends on gdc_pkg and the block's RTL.
`default_nettype none

module tb_top;

  typedef struct {
    logic [gdc_pkg::DIST_OUT_W-1:0]  distance;
    logic                            reachable;
    logic [gdc_pkg::COUNT_OUT_W-1:0] comps;
  } query_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = gdc_pkg::CMD_WRITE;
  logic [gdc_pkg::ROW_W-1:0] in_row = '0;
  logic [gdc_pkg::ROW_W-1:0] in_col = '0;
  logic [gdc_pkg::WEIGHT_IN_W-1:0] in_weight = '0;
  logic cfg_we = 1'b0;
  logic [gdc_pkg::NODE_COUNT_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [gdc_pkg::DIST_OUT_W-1:0] out_distance;
  logic out_reachable;
  logic [gdc_pkg::COUNT_OUT_W-1:0] out_component_count;

  // Model state.
  logic [7:0] weights [16][16];
  logic [4:0] nodes_in_use;
  query_result_t pending_results[$];
  int fail_count = 0;
  int cycles = 0;
  int burst_left = 0;

  graph_distance_and_components DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_row(in_row), .in_col(in_col), .in_weight(in_weight),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_distance(out_distance),
    .out_reachable(out_reachable), .out_component_count(out_component_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle limit: the slowest run is the random test of 1800 words plus gaps.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Predict the result of a query on the current store.
  function automatic query_result_t predict_query(input logic [3:0] src, input logic [3:0] dst);
    query_result_t r;
    int n;
    bit marked [16];
    int stack_a [16];
    int top;
    int cnt;
    int u;
    longint d [16];
    bit changed;
    n = (nodes_in_use > 16) ? 16 : nodes_in_use;
    cnt = 0;
    for (int s = 0; s < 16; s++) marked[s] = 0;
    for (int s = 0; s < n; s++) begin
      if (!marked[s]) begin
        marked[s] = 1;
        top = 0;
        stack_a[top] = s;
        top++;
        while (top > 0) begin
          top--;
          u = stack_a[top];
          for (int v = 0; v < n; v++)
            if (weights[u][v] != 0 && !marked[v]) begin
              marked[v] = 1;
              stack_a[top] = v;
              top++;
            end
        end
        cnt++;
      end
    end
    r.comps = gdc_pkg::COUNT_OUT_W'((cnt > gdc_pkg::COUNT_SAT) ? gdc_pkg::COUNT_SAT : cnt);
    r.distance = '0;
    r.reachable = 1'b0;
    if (src < n && dst < n) begin
      for (int i = 0; i < 16; i++) d[i] = -1;
      d[src] = 0;
      for (int rd = 0; rd < n; rd++) begin
        changed = 0;
        for (int a = 0; a < n; a++) begin
          if (d[a] >= 0) begin
            for (int b = 0; b < n; b++)
              if (weights[a][b] != 0 && (d[b] < 0 || d[a] + weights[a][b] < d[b])) begin
                d[b] = d[a] + weights[a][b];
                changed = 1;
              end
          end
        end
        if (!changed) break;
      end
      if (d[dst] >= 0) begin
        r.reachable = 1'b1;
        r.distance = gdc_pkg::DIST_OUT_W'((d[dst] > gdc_pkg::DIST_SAT) ? gdc_pkg::DIST_SAT
                                                                        : d[dst]);
      end
    end
    return r;
  endfunction

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    query_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_distance !== e.distance) begin
          $error("distance: expected %0d, actual %0d", e.distance, out_distance);
          fail_count++;
        end
        if (out_reachable !== e.reachable) begin
          $error("reachable: expected %0d, actual %0d", e.reachable, out_reachable);
          fail_count++;
        end
        if (out_component_count !== e.comps) begin
          $error("component_count: expected %0d, actual %0d", e.comps,
                 out_component_count);
          fail_count++;
        end
      end
    end
  end

  // Send one word; bursts with random gaps between them. Start stays high within a burst.
  task automatic send_word(input logic cmd, input logic [3:0] r, input logic [3:0] c,
                           input logic [7:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_cmd <= cmd;
    in_row <= r;
    in_col <= c;
    in_weight <= w;
    do @(posedge clk); while (busy);
    if (cmd == gdc_pkg::CMD_WRITE) weights[r][c] = w;
    else pending_results.insert(pending_results.size(), predict_query(r, c));
    @(negedge clk);
  endtask

  // Wait until every predicted word has come, plus settling time.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_node_count(input logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    nodes_in_use = v;
  endtask

  task automatic clear_store();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        if (weights[r][c] != 0) send_word(gdc_pkg::CMD_WRITE, 4'(r), 4'(c), 8'd0);
  endtask

  // Directed: extremes, self query, the longest chain of heaviest edges and a shortcut.
  task automatic test_directed();
    send_word(gdc_pkg::CMD_QUERY, 4'd0, 4'd0, 8'hff);
    send_word(gdc_pkg::CMD_QUERY, 4'd15, 4'd0, 8'd0);
    // A chain of heaviest edges through all sixteen nodes.
    for (int i = 0; i < 15; i++) send_word(gdc_pkg::CMD_WRITE, 4'(i), 4'(i + 1), 8'hff);
    send_word(gdc_pkg::CMD_QUERY, 4'd0, 4'd15, 8'd0);
    send_word(gdc_pkg::CMD_QUERY, 4'd15, 4'd0, 8'd0);
    send_word(gdc_pkg::CMD_WRITE, 4'd0, 4'd15, 8'd1);
    send_word(gdc_pkg::CMD_QUERY, 4'd0, 4'd15, 8'h00);
    send_word(gdc_pkg::CMD_WRITE, 4'd0, 4'd15, 8'd0);
    send_word(gdc_pkg::CMD_QUERY, 4'd7, 4'd7, 8'd0);
    clear_store();
  endtask

  // Node count extremes, zero included, with queries across the boundary.
  task automatic test_node_counts();
    logic [4:0] settings [6] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd5, 5'd16};
    foreach (settings[k]) begin
      set_node_count(settings[k]);
      send_word(gdc_pkg::CMD_WRITE, 4'd0, 4'd1, 8'd3);
      send_word(gdc_pkg::CMD_QUERY, 4'd0, 4'd1, 8'd0);
      send_word(gdc_pkg::CMD_QUERY, 4'd0, 4'd0, 8'd0);
      send_word(gdc_pkg::CMD_QUERY, 4'd4, 4'd15, 8'd0);
    end
    clear_store();
  endtask

  // Random graphs: mostly edge writes, some of them zero, with queries between; small node counts are fastest.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) begin
        set_node_count(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16)));
        if (i == 600) drain();
      end
      if ($urandom_range(0, 9) < 6)
        send_word(gdc_pkg::CMD_WRITE, 4'($urandom), 4'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      else
        send_word(gdc_pkg::CMD_QUERY, 4'($urandom), 4'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) weights[r][c] = '0;
    nodes_in_use = gdc_pkg::NODE_COUNT_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_node_counts();
    test_random(1800);
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/gdc_pkg.sv
sv/gdc_cell.sv
sv/graph_distance_and_components.sv
sv/gdc_checker.sv
sim/tb_top.sv
